>>> design/area_average_downscaler_macros.svh
// Assertion macros for the area-averaging downscaler controller.
// Depends on nothing; included by the files that carry assertions.
`ifndef AREA_AVERAGE_DOWNSCALER_MACROS_SVH
`define AREA_AVERAGE_DOWNSCALER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AAD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/aad_pkg.sv
// Package for the area-averaging downscaler: widths, register indexes,
// command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package aad_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int CFG_W     = 13;
   localparam int PIX_W     = 8;
   localparam int POS_W     = 12;
   localparam int SUM_W     = 32;
   localparam int CSR_IDX_W = 8;
   localparam int DIV_STEPS = 9;
   localparam int DCW       = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = CSR_IDX_W'(3);

   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = CFG_W'(480);
   localparam logic [CFG_W-1:0] RST_DST_WIDTH  = CFG_W'(320);
   localparam logic [CFG_W-1:0] RST_DST_HEIGHT = CFG_W'(240);

   // Accumulator slots touched by one source pixel.
   localparam logic [1:0] SLOT_CUR_COL  = 2'd0;
   localparam logic [1:0] SLOT_CUR_NEXT = 2'd1;
   localparam logic [1:0] SLOT_NXT_COL  = 2'd2;
   localparam logic [1:0] SLOT_NXT_NEXT = 2'd3;

   typedef struct packed {
      logic       clear_start;
      logic       clear_step;
      logic       load_pixel;
      logic       mem_read;
      logic       mem_write;
      logic       div_start;
      logic       div_step;
      logic       out_load;
      logic [1:0] slot;
   } aad_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [3:0] slot_need;
      logic       cell_done;
      logic       out_free;
   } aad_status_type;

endpackage

>>> design/aad_ifs.sv
// Handshake channel interfaces: source pixels, result pixels, register writes.
// Depends on aad_pkg for field widths.
`timescale 1ns / 1ps

interface aad_pix_if;
   logic                      valid;
   logic                      ready;
   logic [aad_pkg::PIX_W-1:0] red;
   logic [aad_pkg::PIX_W-1:0] green;
   logic [aad_pkg::PIX_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface aad_res_if;
   logic                      valid;
   logic                      ready;
   logic [aad_pkg::PIX_W-1:0] out_red;
   logic [aad_pkg::PIX_W-1:0] out_green;
   logic [aad_pkg::PIX_W-1:0] out_blue;
   logic [aad_pkg::POS_W-1:0] dst_col;
   logic [aad_pkg::POS_W-1:0] dst_row;
   logic                      frame_last;
   modport source (output valid, out_red, out_green, out_blue, dst_col, dst_row,
                   frame_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, dst_col, dst_row,
                   frame_last, output ready);
endinterface

interface aad_csr_if;
   logic                          valid;
   logic                          ready;
   logic [aad_pkg::CSR_IDX_W-1:0] index;
   logic [aad_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/area_average_downscaler.sv
// Top level of the area-averaging RGB downscaler: size registers,
// controller and datapath. Depends on aad_pkg, the channel interfaces,
// aad_csr, aad_ctrl and aad_dpath.
//
//   channel   port     direction   carries
//   source    req_if   in          red, green, blue
//   result    rsp_if   out         out_red/green/blue, dst_col, dst_row, frame_last
//   sizes     csr_if   in          index, data (13-bit size)
//
// A pixel is first accepted; then each accumulator it touches (1 to 4) is read,
// then added to and written back on the single memory port; when the pixel completes
// a destination pixel, the divider runs and the result is loaded once the output is free.
// After reset and after every size write a clearing pass over 2*2^clog2(MAX_WIDTH)
// entries zeroes the sums; no pixel is taken meanwhile.
// A waiting result only holds the block once the next one is ready to load.
`timescale 1ns / 1ps

module area_average_downscaler #(
   parameter int MAX_WIDTH  = aad_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aad_pkg::MAX_HEIGHT_DEF
) (
   input logic        clock,
   input logic        reset,
   aad_pix_if.sink    req_if,
   aad_res_if.source  rsp_if,
   aad_csr_if.sink    csr_if
);
   localparam int SZW = $clog2(MAX_WIDTH+1);
   localparam int SZH = $clog2(MAX_HEIGHT+1);

   logic [SZW-1:0]     sw, dw;
   logic [SZH-1:0]     sh, dh;
   logic [SZW+SZH-1:0] area;
   logic               restart;
   logic               req_ready;

   aad_pkg::aad_cmd_type    cmd;
   aad_pkg::aad_status_type status;

   assign req_if.ready = req_ready;

   aad_csr #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_if  (csr_if),
      .sw      (sw),
      .sh      (sh),
      .dw      (dw),
      .dh      (dh),
      .area    (area),
      .restart (restart)
   );

   aad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aad_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .red    (req_if.red),
      .green  (req_if.green),
      .blue   (req_if.blue),
      .sw     (sw),
      .sh     (sh),
      .dw     (dw),
      .dh     (dh),
      .area   (area),
      .cmd    (cmd),
      .status (status),
      .rsp_if (rsp_if)
   );
endmodule

>>> design/aad_csr.sv
// Size registers with clamping to effective sizes and the cell area.
// Depends on aad_pkg and aad_csr_if.
`timescale 1ns / 1ps

module aad_csr #(
   parameter int MAX_WIDTH  = aad_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aad_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   aad_csr_if.sink                                    csr_if,
   output logic [$clog2(MAX_WIDTH+1)-1:0]             sw,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]            sh,
   output logic [$clog2(MAX_WIDTH+1)-1:0]             dw,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]            dh,
   output logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] area,
   output logic                                       restart
);
   localparam int SZW = $clog2(MAX_WIDTH+1);
   localparam int SZH = $clog2(MAX_HEIGHT+1);
   localparam int EW  = (SZW > aad_pkg::CFG_W) ? SZW + 1 : aad_pkg::CFG_W + 1;
   localparam int EH  = (SZH > aad_pkg::CFG_W) ? SZH + 1 : aad_pkg::CFG_W + 1;

   logic [aad_pkg::CFG_W-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [aad_pkg::CFG_W-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [SZW-1:0]            sw_ff, dw_ff;
   logic [SZH-1:0]            sh_ff, dh_ff;
   logic [SZW+SZH-1:0]        area_ff;
   logic [EW-1:0]             sw_c, dw_c;
   logic [EH-1:0]             sh_c, dh_c;
   logic                      fire;

   assign csr_if.ready = 1'b1;
   assign fire = csr_if.valid && csr_if.ready;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      restart  = 1'b0;
      if (fire) begin
         restart = 1'b1;
         unique case (csr_if.index)
            aad_pkg::REG_SRC_WIDTH:  src_w_in = csr_if.data;
            aad_pkg::REG_SRC_HEIGHT: src_h_in = csr_if.data;
            aad_pkg::REG_DST_WIDTH:  dst_w_in = csr_if.data;
            aad_pkg::REG_DST_HEIGHT: dst_h_in = csr_if.data;
            default:                 restart  = 1'b0;
         endcase
      end
   end

   // Zero sizes act as one; sources are clamped to the maximum, destination never exceeds the source.
   always_comb begin
      sw_c = EW'(src_w_ff);
      if (sw_c == '0) sw_c = EW'(1);
      else if (sw_c > EW'(MAX_WIDTH)) sw_c = EW'(MAX_WIDTH);
      sh_c = EH'(src_h_ff);
      if (sh_c == '0) sh_c = EH'(1);
      else if (sh_c > EH'(MAX_HEIGHT)) sh_c = EH'(MAX_HEIGHT);
      dw_c = EW'(dst_w_ff);
      if (dw_c == '0) dw_c = EW'(1);
      else if (dw_c > sw_c) dw_c = sw_c;
      dh_c = EH'(dst_h_ff);
      if (dh_c == '0) dh_c = EH'(1);
      else if (dh_c > sh_c) dh_c = sh_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= aad_pkg::RST_SRC_WIDTH;
         src_h_ff <= aad_pkg::RST_SRC_HEIGHT;
         dst_w_ff <= aad_pkg::RST_DST_WIDTH;
         dst_h_ff <= aad_pkg::RST_DST_HEIGHT;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_ff   <= SZW'(sw_c);
      sh_ff   <= SZH'(sh_c);
      dw_ff   <= SZW'(dw_c);
      dh_ff   <= SZH'(dh_c);
      area_ff <= sw_ff * sh_ff;
   end

   assign sw   = sw_ff;
   assign sh   = sh_ff;
   assign dw   = dw_ff;
   assign dh   = dh_ff;
   assign area = area_ff;
endmodule

>>> design/aad_ctrl.sv
// Controller state machine: clearing pass, per-slot accumulate sequence,
// division and result hand-off. Depends on aad_pkg and the macros header.
`timescale 1ns / 1ps
`include "area_average_downscaler_macros.svh"

module aad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  aad_pkg::aad_status_type status,
   output aad_pkg::aad_cmd_type    cmd
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              slot_ff, slot_in;
   logic [aad_pkg::DCW-1:0] cnt_ff, cnt_in;
   logic [1:0]              nxt_slot;
   logic                    nxt_found;

   // Smallest needed slot above the current one.
   always_comb begin
      nxt_found = 1'b0;
      nxt_slot  = slot_ff;
      for (int i = 3; i >= 1; i--) begin
         if (2'(i) > slot_ff && status.slot_need[i]) begin
            nxt_found = 1'b1;
            nxt_slot  = 2'(i);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.slot = slot_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               slot_in        = aad_pkg::SLOT_CUR_COL;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.mem_write = 1'b1;
            if (slot_ff == aad_pkg::SLOT_CUR_COL && status.cell_done) cmd.div_start = 1'b1;
            if (nxt_found) begin
               slot_in  = nxt_slot;
               state_in = ST_READ;
            end else if (status.cell_done) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == aad_pkg::DCW'(aad_pkg::DIV_STEPS - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (restart) begin
         cmd             = '0;
         cmd.slot        = slot_ff;
         cmd.clear_start = 1'b1;
         state_in        = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         slot_ff  <= aad_pkg::SLOT_CUR_COL;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         cnt_ff   <= cnt_in;
      end
   end

   `AAD_ASSERT_NEXT(a_accept_reads, clock, reset,
      req_valid && req_ready && !restart, state_ff == ST_READ,
      "accepted pixel did not start an accumulator read")
   `AAD_ASSERT_SAME(a_div_count, clock, reset,
      state_ff == ST_DIV, cnt_ff < aad_pkg::DCW'(aad_pkg::DIV_STEPS),
      "division ran past its step count")
   `AAD_ASSERT_SAME(a_load_free, clock, reset,
      cmd.out_load, status.out_free,
      "result loaded over one not yet transferred")
   `AAD_ASSERT_NEXT(a_clear_ends, clock, reset,
      state_ff == ST_CLEAR && status.clear_last && !restart, state_ff == ST_IDLE,
      "clearing pass did not end after the last entry")
endmodule

>>> design/aad_dpath.sv
// Datapath: position tracking, overlap weights, accumulator memory,
// restoring divider and result register. Depends on aad_pkg and aad_res_if.
`timescale 1ns / 1ps

module aad_dpath #(
   parameter int MAX_WIDTH  = aad_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = aad_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [aad_pkg::PIX_W-1:0]                  red,
   input  logic [aad_pkg::PIX_W-1:0]                  green,
   input  logic [aad_pkg::PIX_W-1:0]                  blue,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]             sw,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]            sh,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]             dw,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]            dh,
   input  logic [$clog2(MAX_WIDTH+1)+$clog2(MAX_HEIGHT+1)-1:0] area,
   input  aad_pkg::aad_cmd_type                       cmd,
   output aad_pkg::aad_status_type                    status,
   aad_res_if.source                                  rsp_if
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int SZW   = $clog2(MAX_WIDTH+1);
   localparam int SZH   = $clog2(MAX_HEIGHT+1);
   localparam int AW    = SZW + SZH;
   localparam int SW_   = aad_pkg::SUM_W;
   localparam int PW    = aad_pkg::PIX_W;
   localparam int NW    = SW_ + 2;
   localparam int DVW   = (NW > AW + aad_pkg::DIV_STEPS) ? NW : AW + aad_pkg::DIV_STEPS;
   localparam int DEPTH = 2 ** (CW + 1);

   // Position of the next source pixel; rem is the offset inside its cell.
   logic [CW-1:0]  x_ff, cx_ff;
   logic [RW-1:0]  y_ff, cy_ff;
   logic [SZW-1:0] xrem_ff;
   logic [SZH-1:0] yrem_ff;

   // Latched pixel and its geometry.
   logic [PW-1:0]  pix_ff [3];
   logic [CW-1:0]  pcx_ff;
   logic [RW-1:0]  pcy_ff;
   logic [SZW-1:0] wx0_ff, wx1_ff;
   logic [SZH-1:0] hy0_ff, hy1_ff;
   logic [3:0]     need_ff;
   logic           done_ff, last_ff;

   logic [SZW:0]   xsum;
   logic [SZH:0]   ysum;
   logic           col_done, row_done, row_end, frame_end;
   logic [SZW-1:0] wx0, wx1, x_inc, cx_inc;
   logic [SZH-1:0] hy0, hy1, y_inc, cy_inc;

   logic [AW-1:0]       weight_ff;
   logic [CW-1:0]       col;
   logic [CW:0]         addr, clr_ff;
   logic [3*SW_-1:0]    mem [DEPTH];
   logic [3*SW_-1:0]    rd_ff, wr_data;
   logic [SW_-1:0]      acc_sum [3];
   logic [PW+AW-1:0]    prod [3];

   logic [DVW-1:0]              rem_ff [3];
   logic [DVW-1:0]              dsh_ff;
   logic [aad_pkg::DIV_STEPS-1:0] q_ff [3];

   logic rsp_valid_ff;

   always_comb begin
      xsum     = {1'b0, xrem_ff} + {1'b0, dw};
      ysum     = {1'b0, yrem_ff} + {1'b0, dh};
      col_done = (xsum >= {1'b0, sw});
      row_done = (ysum >= {1'b0, sh});
      wx0      = col_done ? sw - xrem_ff : dw;
      wx1      = dw - wx0;
      hy0      = row_done ? sh - yrem_ff : dh;
      hy1      = dh - hy0;
      x_inc    = SZW'(x_ff) + SZW'(1);
      y_inc    = SZH'(y_ff) + SZH'(1);
      cx_inc   = SZW'(cx_ff) + SZW'(1);
      cy_inc   = SZH'(cy_ff) + SZH'(1);
      row_end  = (x_inc == sw);
      frame_end = row_end && (y_inc == sh);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) begin
         x_ff    <= '0;
         y_ff    <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         xrem_ff <= '0;
         yrem_ff <= '0;
      end else if (cmd.load_pixel) begin
         if (row_end) begin
            x_ff    <= '0;
            cx_ff   <= '0;
            xrem_ff <= '0;
            if (frame_end) begin
               y_ff    <= '0;
               cy_ff   <= '0;
               yrem_ff <= '0;
            end else begin
               y_ff    <= RW'(y_inc);
               cy_ff   <= row_done ? RW'(cy_inc) : cy_ff;
               yrem_ff <= row_done ? SZH'(ysum - {1'b0, sh}) : SZH'(ysum);
            end
         end else begin
            x_ff    <= CW'(x_inc);
            cx_ff   <= col_done ? CW'(cx_inc) : cx_ff;
            xrem_ff <= col_done ? SZW'(xsum - {1'b0, sw}) : SZW'(xsum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_ff[0]  <= red;
         pix_ff[1]  <= green;
         pix_ff[2]  <= blue;
         pcx_ff     <= cx_ff;
         pcy_ff     <= cy_ff;
         wx0_ff     <= wx0;
         wx1_ff     <= wx1;
         hy0_ff     <= hy0;
         hy1_ff     <= hy1;
         need_ff[0] <= 1'b1;
         need_ff[1] <= (cx_inc < dw);
         need_ff[2] <= (cy_inc < dh);
         need_ff[3] <= (cx_inc < dw) && (cy_inc < dh);
         done_ff    <= col_done && row_done;
         last_ff    <= (cx_inc == dw) && (cy_inc == dh);
      end
   end

   // Slot address: bit 0 picks the right-hand column, bit 1 the other bank.
   assign col  = cmd.slot[0] ? pcx_ff + 1'b1 : pcx_ff;
   assign addr = {pcy_ff[0] ^ cmd.slot[1], col};

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_ff     <= mem[addr];
         weight_ff <= (cmd.slot[0] ? wx1_ff : wx0_ff) * (cmd.slot[1] ? hy1_ff : hy0_ff);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c]    = pix_ff[c] * weight_ff;
         acc_sum[c] = rd_ff[c*SW_ +: SW_] + SW_'(prod[c]);
      end
      if (cmd.slot == aad_pkg::SLOT_CUR_COL && done_ff) wr_data = '0;
      else wr_data = {acc_sum[2], acc_sum[1], acc_sum[0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.mem_write) mem[addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // Round half up: floor((2*sum + area) / (2*area)), one quotient bit a step.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dsh_ff <= DVW'({area, 1'b0}) << (aad_pkg::DIV_STEPS - 1);
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= DVW'(NW'({acc_sum[c], 1'b0}) + NW'(area));
            q_ff[c]   <= '0;
         end
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= dsh_ff) begin
               rem_ff[c] <= rem_ff[c] - dsh_ff;
               q_ff[c]   <= {q_ff[c][aad_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
               q_ff[c]   <= {q_ff[c][aad_pkg::DIV_STEPS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_if.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_if.out_red    <= q_ff[0][PW-1:0];
         rsp_if.out_green  <= q_ff[1][PW-1:0];
         rsp_if.out_blue   <= q_ff[2][PW-1:0];
         rsp_if.dst_col    <= aad_pkg::POS_W'(pcx_ff);
         rsp_if.dst_row    <= aad_pkg::POS_W'(pcy_ff);
         rsp_if.frame_last <= last_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign status.clear_last = &clr_ff;
   assign status.slot_need  = need_ff;
   assign status.cell_done  = done_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_if.ready;
endmodule

>>> test/area_average_downscaler_test.sv
// Self-checking test of the area-averaging downscaler: random and directed
// frames, checked pixel by pixel. Depends on aad_pkg, aad_ifs and the block.
`timescale 1ns / 1ps

module area_average_downscaler_test;

   localparam int MAXW = aad_pkg::MAX_WIDTH_DEF;
   localparam int MAXH = aad_pkg::MAX_HEIGHT_DEF;
   localparam int STALL_LIMIT = 40000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [aad_pkg::PIX_W-1:0] red;
      logic [aad_pkg::PIX_W-1:0] green;
      logic [aad_pkg::PIX_W-1:0] blue;
      logic [aad_pkg::POS_W-1:0] col;
      logic [aad_pkg::POS_W-1:0] row;
      logic                      last;
   } dst_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aad_pix_if req_if ();
   aad_res_if rsp_if ();
   aad_csr_if csr_if ();

   area_average_downscaler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always #6 clock = ~clock;

   // Model state: sizes, sums in two row banks and the source position.
   logic [aad_pkg::CFG_W-1:0] size_reg [4];
   logic [31:0] acc_red [2*MAXW];
   logic [31:0] acc_green [2*MAXW];
   logic [31:0] acc_blue [2*MAXW];
   int unsigned src_x, src_y;
   dst_pixel_type pending_pixels [$];

   int mismatches = 0;
   int pixels_seen = 0;
   int pixels_sent = 0;
   int idle_pct = 28;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit timed_out = 1'b0;

   function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_model();
      for (int i = 0; i < 2*MAXW; i++) begin
         acc_red[i] = '0;
         acc_green[i] = '0;
         acc_blue[i] = '0;
      end
      src_x = 0;
      src_y = 0;
   endfunction

   function automatic void add_weighted(int idx, longint unsigned w,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (w == 0) return;
      acc_red[idx] = 32'(acc_red[idx] + r * w);
      acc_green[idx] = 32'(acc_green[idx] + g * w);
      acc_blue[idx] = 32'(acc_blue[idx] + b * w);
   endfunction

   function automatic logic [7:0] rounded_mean(logic [31:0] s, longint unsigned area);
      longint unsigned q;
      q = (2 * longint'(s) + area) / (2 * area);
      return q[7:0];
   endfunction

   // Folds one source pixel into the sums and queues any finished pixel.
   function automatic void downscale_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint unsigned sw, sh, dw, dh, xs, ys, cx, cy, xend, yend;
      longint unsigned wx0, wx1, hy0, hy1, area;
      int cur, nxt, i;
      dst_pixel_type px;
      sw = clamp_dim(size_reg[aad_pkg::REG_SRC_WIDTH], MAXW);
      sh = clamp_dim(size_reg[aad_pkg::REG_SRC_HEIGHT], MAXH);
      dw = clamp_dim(size_reg[aad_pkg::REG_DST_WIDTH], sw);
      dh = clamp_dim(size_reg[aad_pkg::REG_DST_HEIGHT], sh);
      if (src_x >= sw || src_y >= sh) begin
         src_x = 0;
         src_y = 0;
      end
      xs = src_x * dw;
      ys = src_y * dh;
      cx = xs / sw;
      cy = ys / sh;
      xend = (cx + 1) * sw;
      yend = (cy + 1) * sh;
      wx0 = (xs + dw <= xend) ? dw : xend - xs;
      wx1 = dw - wx0;
      hy0 = (ys + dh <= yend) ? dh : yend - ys;
      hy1 = dh - hy0;
      cur = int'(cy[0]) * MAXW;
      nxt = int'(!cy[0]) * MAXW;
      add_weighted(cur + int'(cx), wx0 * hy0, r, g, b);
      if (cx + 1 < dw) add_weighted(cur + int'(cx) + 1, wx1 * hy0, r, g, b);
      if (cy + 1 < dh) begin
         add_weighted(nxt + int'(cx), wx0 * hy1, r, g, b);
         if (cx + 1 < dw) add_weighted(nxt + int'(cx) + 1, wx1 * hy1, r, g, b);
      end
      if (xs + dw >= xend && ys + dh >= yend) begin
         area = sw * sh;
         i = cur + int'(cx);
         px.red = rounded_mean(acc_red[i], area);
         px.green = rounded_mean(acc_green[i], area);
         px.blue = rounded_mean(acc_blue[i], area);
         px.col = cx[aad_pkg::POS_W-1:0];
         px.row = cy[aad_pkg::POS_W-1:0];
         px.last = (cx + 1 == dw && cy + 1 == dh);
         acc_red[i] = '0;
         acc_green[i] = '0;
         acc_blue[i] = '0;
         pending_pixels.push_back(px);
      end
      if (src_x + 1 < sw) begin
         src_x++;
      end else begin
         src_x = 0;
         src_y = (src_y + 1 < sh) ? src_y + 1 : 0;
      end
   endfunction

   // Valid stays high from one transfer into the next unless the sender idles.
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red <= r;
      req_if.green <= g;
      req_if.blue <= b;
      do @(posedge clock); while (!req_if.ready);
      downscale_pixel(r, g, b);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      // A pixel that finishes no destination cell may still be in flight.
      repeat (40) @(negedge clock);
   endtask

   // Writes one size register; the block must be idle.
   task automatic write_size(logic [aad_pkg::CSR_IDX_W-1:0] idx, int value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= aad_pkg::CFG_W'(value);
      do @(posedge clock); while (!csr_if.ready);
      if (idx <= aad_pkg::REG_DST_HEIGHT) begin
         size_reg[idx] = aad_pkg::CFG_W'(value);
         restart_model();
      end
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_sizes(int sw, int sh, int dw, int dh);
      write_size(aad_pkg::REG_SRC_WIDTH, sw);
      write_size(aad_pkg::REG_SRC_HEIGHT, sh);
      write_size(aad_pkg::REG_DST_WIDTH, dw);
      write_size(aad_pkg::REG_DST_HEIGHT, dh);
   endtask

   task automatic send_frames(int n);
      logic [7:0] r, g, b;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(3))
            0: begin
               r = 8'hff; g = 8'hff; b = 8'hff;
            end
            1: begin
               r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            end
            default: begin
               r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            end
         endcase
         send_pixel(r, g, b);
      end
   endtask

   // Extremes of the channel values at a 1:1 scale and a full collapse.
   task automatic test_directed();
      set_sizes(2, 2, 2, 2);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'haa, 8'h55, 8'h0f);
      send_pixel(8'h55, 8'haa, 8'hf0);
      set_sizes(3, 1, 1, 1);
      send_pixel(8'h00, 8'h00, 8'h01);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h01, 8'h00, 8'h00);
      set_sizes(2, 1, 1, 1);
      send_pixel(8'h01, 8'h00, 8'hff);
      send_pixel(8'h00, 8'h01, 8'hfe);
   endtask

   // Zero sizes act as one, a too-large destination is clamped, an unused index is ignored.
   task automatic test_clamping();
      set_sizes(0, 0, 0, 0);
      send_pixel(8'h80, 8'h7f, 8'h01);
      set_sizes(3, 2, 9, 8191);
      send_frames(12);
      write_size(aad_pkg::CSR_IDX_W'(7), 5);
      send_frames(6);
   endtask

   // Long rows folded into a few wide cells with uneven overlaps.
   task automatic test_wide_rows();
      set_sizes(300, 1, 7, 1);
      send_frames(300);
   endtask

   task automatic test_random_sizes(int items);
      int sw, sh, n;
      while (items > 0) begin
         sw = $urandom_range(1, 9);
         sh = $urandom_range(1, 9);
         set_sizes(sw, sh, $urandom_range(1, sw), $urandom_range(1, sh));
         n = sw * sh * $urandom_range(1, 3);
         send_frames(n);
         items -= n;
      end
   endtask

   // The receiver holds off while the sender keeps the block full.
   task automatic test_backpressure();
      set_sizes(2, 2, 2, 2);
      hold_request = 1'b1;
      send_frames(40);
      send_frames(40);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.red = '0;
      req_if.green = '0;
      req_if.blue = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      size_reg[aad_pkg::REG_SRC_WIDTH] = aad_pkg::RST_SRC_WIDTH;
      size_reg[aad_pkg::REG_SRC_HEIGHT] = aad_pkg::RST_SRC_HEIGHT;
      size_reg[aad_pkg::REG_DST_WIDTH] = aad_pkg::RST_DST_WIDTH;
      size_reg[aad_pkg::REG_DST_HEIGHT] = aad_pkg::RST_DST_HEIGHT;
      restart_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_frames(650);
      test_directed();
      test_clamping();
      test_wide_rows();
      idle_pct = 0;
      test_random_sizes(200);
      idle_pct = 28;
      test_random_sizes(400);
      test_backpressure();
      wait_drained();
      $display("Sent %0d source pixels over many frame sizes, checked %0d results.",
               pixels_sent, pixels_seen);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("area_average_downscaler_test passed");
      end else begin
         $display("area_average_downscaler_test failed");
      end
      $finish;
   end

   // Receiver: random ready, always ready when idle_pct is zero, or a hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_pct == 0) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      dst_pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result with none expected at row %0d col %0d",
                                           rsp_if.dst_row, rsp_if.dst_col);
         end else begin
            want = pending_pixels.pop_front();
            if (want.red !== rsp_if.out_red || want.green !== rsp_if.out_green ||
                want.blue !== rsp_if.out_blue || want.col !== rsp_if.dst_col ||
                want.row !== rsp_if.dst_row || want.last !== rsp_if.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected rgb %h %h %h at %0d,%0d last %b; ",
                            "got %h %h %h at %0d,%0d last %b"},
                           want.red, want.green, want.blue, want.row, want.col, want.last,
                           rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue,
                           rsp_if.dst_row, rsp_if.dst_col, rsp_if.frame_last);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out <= 1'b1;
         $display("Timeout: no transfer in %0d cycles", STALL_LIMIT);
         $display("area_average_downscaler_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
